>>> rtl/thpc_pkg.sv
// ----------------------------------------------------------------------------
// thpc_pkg
// types and constants shared by the tcp header parse and checksum block
// ----------------------------------------------------------------------------
package thpc_pkg;

    localparam int unsigned MIN_HDR_BYTES = 20;
    localparam int unsigned MAX_HDR_BYTES = 60;
    localparam int unsigned HDR_IDX_W     = $clog2(MIN_HDR_BYTES);

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EOF       = 2'd1,
        STATUS_MALFORMED = 2'd2,
        STATUS_CSUM_BAD  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] segment_length;
        logic [31:0] pseudo_sum;
    } thpc_in_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [3:0]  hdr_words;
        logic [7:0]  flag_bits;
        logic [15:0] rx_window;
        logic [15:0] checksum_field;
        logic [15:0] urg_ptr;
        logic [5:0]  payload_offset;
    } thpc_out_t;

    // segment state captured on the closing byte, checked in the next stage
    typedef struct packed {
        logic        eof;
        logic        malformed;
        logic [31:0] sum;
        logic        pad_en;
        logic [7:0]  pad_byte;
        thpc_out_t   fields;
    } thpc_snap_t;

endpackage

>>> rtl/tcp_header_parse_check.sv
// ----------------------------------------------------------------------------
// tcp_header_parse_check
// tcp header parser with one's-complement checksum check; while s_ready is high, one byte per cycle
// ----------------------------------------------------------------------------
//  port    | dir | payload     | role
//  s_*     | in  | thpc_in_t   | segment bytes, first/last marks, length, pseudo sum
//  m_*     | out | thpc_out_t  | one result per byte marked last
//
//  one byte is taken every cycle while s_ready is high; the byte count, header capture and sum
//  update run in the cycle a byte is taken.
//  after its last byte a result passes through one register that holds the
//  captured segment, then the next that holds the checked and folded result.
//  aresetn is synchronous; it clears the segment state and both valid flags.
//  a stalled m_ready holds the result; s_ready drops only when both stages
//  hold a result.
// ----------------------------------------------------------------------------
module tcp_header_parse_check (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  thpc_pkg::thpc_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output thpc_pkg::thpc_out_t  m_data
);
    import thpc_pkg::*;

    thpc_snap_t snap;
    thpc_snap_t snap_reg;
    logic       snap_valid_reg;
    logic       snap_valid_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    thpc_out_t  m_data_reg;
    thpc_out_t  m_data_next;

    logic        fire;
    logic        out_free;
    logic [31:0] pad_word;
    logic [32:0] add_wide;
    logic [31:0] sum_pad;
    logic [16:0] fold_a;
    logic [15:0] fold_b;

    thpc_capture u_capture (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (s_data),
        .snap    (snap)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !snap_valid_reg || out_free;
    assign fire     = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        pad_word = snap_reg.pad_en ? {16'd0, snap_reg.pad_byte, 8'd0} : 32'd0;
        add_wide = {1'b0, snap_reg.sum} + {1'b0, pad_word};
        sum_pad  = add_wide[31:0] + {31'd0, add_wide[32]};
        fold_a   = {1'b0, sum_pad[15:0]} + {1'b0, sum_pad[31:16]};
        fold_b   = fold_a[15:0] + {15'd0, fold_a[16]};

        m_data_next = snap_reg.fields;
        if (snap_reg.eof) begin
            m_data_next        = '0;
            m_data_next.status = STATUS_EOF;
        end else if (snap_reg.malformed) begin
            m_data_next.status = STATUS_MALFORMED;
        end else if (fold_b != 16'hFFFF) begin
            m_data_next.status = STATUS_CSUM_BAD;
        end else begin
            m_data_next.status = STATUS_OK;
        end

        snap_valid_next = (fire && s_data.last_byte) ? 1'b1 :
                          (out_free ? 1'b0 : snap_valid_reg);
        m_valid_next    = out_free ? snap_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            snap_valid_reg <= snap_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && s_data.last_byte) begin
            snap_reg <= snap;
        end
        if (out_free && snap_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    a_eof_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.status == STATUS_EOF |->
            m_data_reg.sport == 16'd0 && m_data_reg.seq_num == 32'd0 &&
            m_data_reg.payload_offset == 6'd0 && m_data_reg.flag_bits == 8'd0)
        else $error("eof result carries decoded fields");

    a_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.status != STATUS_EOF |->
            m_data_reg.payload_offset == {m_data_reg.hdr_words, 2'b00})
        else $error("payload offset disagrees with data offset");

    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.status == STATUS_OK |->
            m_data_reg.payload_offset >= 6'(MIN_HDR_BYTES) &&
            m_data_reg.payload_offset <= 6'(MAX_HDR_BYTES))
        else $error("ok result with out of range header length");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> snap_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled while a stage is free");

    a_move: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_valid_reg && out_free |=> m_valid_reg)
        else $error("captured segment lost on the way to the output");

endmodule

>>> rtl/thpc_capture.sv
// ----------------------------------------------------------------------------
// thpc_capture
// per-byte segment state: header capture, byte count and running sum
// ----------------------------------------------------------------------------
module thpc_capture (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  thpc_pkg::thpc_in_t  item,
    output thpc_pkg::thpc_snap_t snap
);
    import thpc_pkg::*;

    logic [15:0] byte_count_reg;
    logic [15:0] byte_count_next;
    logic [7:0]  hdr_reg  [MIN_HDR_BYTES];
    logic [7:0]  hdr_next [MIN_HDR_BYTES];
    logic [31:0] running_sum_reg;
    logic [31:0] running_sum_next;
    logic [7:0]  held_byte_reg;
    logic [7:0]  held_byte_next;
    logic [15:0] latched_length_reg;
    logic [15:0] latched_length_next;

    logic [15:0] cnt;
    logic [31:0] sum_base;
    logic [7:0]  held_base;
    logic [32:0] add_wide;
    logic [31:0] sum_add;
    logic        in_len;
    logic        in_hdr;
    logic [5:0]  hdr_len;

    always_comb begin
        cnt                 = item.first_byte ? 16'd0 : byte_count_reg;
        latched_length_next = item.first_byte ? item.segment_length : latched_length_reg;
        sum_base            = item.first_byte ? item.pseudo_sum : running_sum_reg;
        held_base           = item.first_byte ? 8'd0 : held_byte_reg;

        in_hdr = cnt < 16'(MIN_HDR_BYTES);
        for (int i = 0; i < MIN_HDR_BYTES; i++) begin
            hdr_next[i] = (in_hdr && cnt[HDR_IDX_W-1:0] == HDR_IDX_W'(i)) ?
                          item.data_byte : hdr_reg[i];
        end

        add_wide = {1'b0, sum_base} + {17'd0, held_base, item.data_byte};
        sum_add  = add_wide[31:0] + {31'd0, add_wide[32]};
        in_len   = cnt < latched_length_next;

        held_byte_next   = (in_len && !cnt[0]) ? item.data_byte : held_base;
        running_sum_next = (in_len && cnt[0]) ? sum_add : sum_base;
        byte_count_next  = (&cnt) ? cnt : cnt + 16'd1;

        hdr_len = {hdr_next[12][7:4], 2'b00};

        snap.eof       = byte_count_next < 16'(MIN_HDR_BYTES);
        snap.malformed = (hdr_len < 6'(MIN_HDR_BYTES)) || (hdr_len > 6'(MAX_HDR_BYTES)) ||
                         (latched_length_next < {10'd0, hdr_len}) ||
                         (byte_count_next < latched_length_next);
        snap.sum       = running_sum_next;
        snap.pad_en    = latched_length_next[0];
        snap.pad_byte  = held_byte_next;

        snap.fields.status         = STATUS_OK;
        snap.fields.sport          = {hdr_next[0], hdr_next[1]};
        snap.fields.dport          = {hdr_next[2], hdr_next[3]};
        snap.fields.seq_num        = {hdr_next[4], hdr_next[5], hdr_next[6], hdr_next[7]};
        snap.fields.ack_num        = {hdr_next[8], hdr_next[9], hdr_next[10], hdr_next[11]};
        snap.fields.hdr_words      = hdr_next[12][7:4];
        snap.fields.flag_bits      = hdr_next[13];
        snap.fields.rx_window      = {hdr_next[14], hdr_next[15]};
        snap.fields.checksum_field = {hdr_next[16], hdr_next[17]};
        snap.fields.urg_ptr        = {hdr_next[18], hdr_next[19]};
        snap.fields.payload_offset = hdr_len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg     <= '0;
            running_sum_reg    <= '0;
            held_byte_reg      <= '0;
            latched_length_reg <= '0;
            for (int i = 0; i < MIN_HDR_BYTES; i++) begin
                hdr_reg[i] <= '0;
            end
        end else if (fire) begin
            byte_count_reg     <= byte_count_next;
            running_sum_reg    <= running_sum_next;
            held_byte_reg      <= held_byte_next;
            latched_length_reg <= latched_length_next;
            for (int i = 0; i < MIN_HDR_BYTES; i++) begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

endmodule
